// ----- sv/hec_pkg.sv -----
// Shared constants and elaboration-time helpers for the Hamming codec.
// No dependencies; every other file of the codec but hec_syn imports this package.
package hec_pkg;

  // Width of the data length register and of the code length value.
  localparam int CFG_W = 6;
  localparam int LEN_W = 6;

  // Operation selector carried on the input tuser bit.
  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  // Smallest parity count r, searched up to 6, with 2^r >= n + r + 1; zero if none fits.
  function automatic int parity_count(input int n);
    int res;
    res = 0;
    for (int r = 6; r >= 0; r--) begin
      if ((1 << r) >= n + r + 1) begin
        res = r;
      end
    end
    return res;
  endfunction

  // True when a codeword position is a power of two (a parity position).
  function automatic bit is_pow2(input int p);
    return (p & (p - 1)) == 0;
  endfunction

  // Data bit index held at a non-power-of-two codeword position.
  function automatic int data_idx(input int p);
    int cnt;
    cnt = 0;
    for (int q = 1; q < p; q++) begin
      if (!is_pow2(q)) begin
        cnt++;
      end
    end
    return cnt;
  endfunction

endpackage

// ----- sv/hamming_encode_correct_codec.sv -----
// Top level of the Hamming single-error-correcting codec: stream ports,
// input register, result register. Depends on hec_pkg, hec_cfg, hec_encode, hec_decode.
//
//   Channel | Direction | Carries
//   --------+-----------+-------------------------------------------------
//   in_     | slave     | tuser = op; tdata = data_in, code_in
//   out_    | master    | tdata = code_out, data_out, syndrome, error_found,
//           |           |         syndrome_out_of_range
//   cfg_    | write     | data_length (6 bits), taken on any edge with cfg_wen
//
// One transaction per cycle sustained while out_tready stays high; the result
// passes the input register at the accepting edge, the XOR trees and then the
// result register.
// The syndrome XOR tree between the two registers sets the cycle time.
// Reset clears both valid flags and loads a data length of 4.
// A stall on the output holds the result and the item behind it, and
// in_tready drops only when both registers are full.
module hamming_encode_correct_codec #(
  parameter int MAX_DATA_BITS = 57
) (
  input  logic clk,
  input  logic rst_n,
  // Input stream.
  input  logic in_tvalid,
  output logic in_tready,
  input  logic in_tuser,  // [0] op
  input  logic [((MAX_DATA_BITS + MAX_DATA_BITS
                  + hec_pkg::parity_count(MAX_DATA_BITS) + 7) / 8) * 8 - 1:0]
               in_tdata,  // data_in, then code_in, then zero fill
  // Result stream.
  output logic out_tvalid,
  input  logic out_tready,
  output logic [((2 * MAX_DATA_BITS + 2 * hec_pkg::parity_count(MAX_DATA_BITS)
                  + 2 + 7) / 8) * 8 - 1:0]
               out_tdata,  // code_out, data_out, syndrome, error_found,
                           // syndrome_out_of_range, then zero fill
  // Configuration write.
  input  logic                      cfg_wen,
  input  logic [hec_pkg::CFG_W-1:0] cfg_wdata
);
  import hec_pkg::*;

  localparam int DW    = MAX_DATA_BITS;
  localparam int R     = parity_count(DW);
  localparam int CW    = DW + R;
  localparam int IN_W  = ((DW + CW + 7) / 8) * 8;
  localparam int RES_W = CW + DW + R + 2;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

  logic [LEN_W-1:0] code_len;
  logic [DW-1:0]    data_mask;
  logic [CW-1:0]    code_mask;

  hec_cfg #(.DW(DW), .CW(CW)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .code_len  (code_len),
    .data_mask (data_mask),
    .code_mask (code_mask)
  );

  // Input register.
  logic          s1_valid_r, s1_valid_nxt;
  op_t           s1_op_r;
  logic [DW-1:0] s1_data_r;
  logic [CW-1:0] s1_code_r;
  logic          s1_adv;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_tdata_r, out_tdata_nxt;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
    out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the transaction payload on acceptance.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= op_t'(in_tuser);
      s1_data_r <= in_tdata[DW-1:0];
      s1_code_r <= in_tdata[DW+CW-1:DW];
    end
  end

  // Encode and decode paths.
  logic [DW-1:0] enc_data;
  logic [CW-1:0] enc_code;
  logic [CW-1:0] dec_code_in, dec_fixed;
  logic [DW-1:0] dec_data;
  logic [R-1:0]  dec_syn;
  logic          dec_err, dec_oor;

  assign enc_data    = s1_data_r & data_mask;
  assign dec_code_in = s1_code_r & code_mask;

  hec_encode #(.DW(DW), .CW(CW), .R(R)) u_enc (
    .data (enc_data),
    .code (enc_code)
  );

  hec_decode #(.DW(DW), .CW(CW), .R(R)) u_dec (
    .code     (dec_code_in),
    .code_len (code_len),
    .fixed    (dec_fixed),
    .data     (dec_data),
    .syn      (dec_syn),
    .err      (dec_err),
    .oor      (dec_oor)
  );

  // Select the result by operation and pack it for the output register.
  always_comb begin
    case (s1_op_r)
      OP_ENCODE: out_tdata_nxt = OUT_W'({2'b00, {R{1'b0}}, enc_data, enc_code});
      OP_DECODE: out_tdata_nxt = OUT_W'({dec_oor, dec_err, dec_syn, dec_data, dec_fixed});
      default:   out_tdata_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // The padding bits of the input beyond the two fields are not used.
  logic unused_in_pad;
  if (IN_W > DW + CW) begin : g_pad
    assign unused_in_pad = ^in_tdata[IN_W-1:DW+CW];
  end else begin : g_nopad
    assign unused_in_pad = 1'b0;
  end

endmodule

// ----- sv/hec_cfg.sv -----
// Data length register of the Hamming codec and the code limits derived from it.
// Depends on hec_pkg.
module hec_cfg #(
  parameter int DW = 57,
  parameter int CW = 63
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wen,
  input  logic [hec_pkg::CFG_W-1:0] cfg_wdata,
  output logic [hec_pkg::LEN_W-1:0] code_len,
  output logic [DW-1:0]           data_mask,
  output logic [CW-1:0]           code_mask
);
  import hec_pkg::*;

  localparam logic [CFG_W-1:0] RESET_LEN = CFG_W'(4);

  logic [LEN_W-1:0] len_r,   len_nxt;
  logic [DW-1:0]    dmask_r, dmask_nxt;
  logic [CW-1:0]    cmask_r, cmask_nxt;

  // Clamp the written length to the supported range and derive the limits.
  function automatic int eff_n(input logic [CFG_W-1:0] v);
    int n;
    n = int'(v);
    if (n < 1) begin
      n = 1;
    end
    if (n > DW) begin
      n = DW;
    end
    return n;
  endfunction

  // Limits for the value being written, so they are ready on the next edge.
  // Reset takes precedence over a write in the same cycle.
  always_comb begin
    int n;
    int len;
    n   = eff_n((rst_n && cfg_wen) ? cfg_wdata : RESET_LEN);
    len = n + parity_count(n);
    len_nxt = LEN_W'(len);
    for (int i = 0; i < DW; i++) begin
      dmask_nxt[i] = (i < n);
    end
    for (int i = 0; i < CW; i++) begin
      cmask_nxt[i] = (i < len);
    end
  end

  // Reset loads the default length; a write loads the new limits.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wen) begin
      len_r   <= len_nxt;
      dmask_r <= dmask_nxt;
      cmask_r <= cmask_nxt;
    end
  end

  assign code_len  = len_r;
  assign data_mask = dmask_r;
  assign code_mask = cmask_r;

endmodule

// ----- sv/hec_syn.sv -----
// Syndrome XOR tree: XOR of the indices of all set codeword positions.
// No dependencies; the encoder and the decoder each instantiate it.
module hec_syn #(
  parameter int CW = 63,
  parameter int R  = 6
) (
  input  logic [CW-1:0] code,
  output logic [R-1:0]  syn
);

  // Each syndrome bit is the parity of the positions whose index has that bit.
  always_comb begin
    syn = '0;
    for (int b = 0; b < R; b++) begin
      for (int p = 1; p <= CW; p++) begin
        if (((p >> b) & 1) == 1) begin
          syn[b] = syn[b] ^ code[p-1];
        end
      end
    end
  end

endmodule

// ----- sv/hec_encode.sv -----
// Encoder: places data bits at non-power-of-two positions and fills parity.
// Depends on hec_pkg and hec_syn.
module hec_encode #(
  parameter int DW = 57,
  parameter int CW = 63,
  parameter int R  = 6
) (
  input  logic [DW-1:0] data,
  output logic [CW-1:0] code
);
  import hec_pkg::*;

  logic [CW-1:0] placed;
  logic [R-1:0]  par;

  // Data placement; parity positions stay zero for the parity pass.
  for (genvar p = 1; p <= CW; p++) begin : g_place
    if (is_pow2(p)) begin : g_par
      assign placed[p-1] = 1'b0;
      assign code[p-1]   = par[$clog2(p)];
    end else begin : g_dat
      assign placed[p-1] = data[data_idx(p)];
      assign code[p-1]   = placed[p-1];
    end
  end

  // The syndrome of the data-only word is the parity needed at each 2^i.
  hec_syn #(.CW(CW), .R(R)) u_syn (
    .code (placed),
    .syn  (par)
  );

endmodule

// ----- sv/hec_decode.sv -----
// Decoder: computes the syndrome, flips the indicated bit, extracts data.
// Depends on hec_pkg and hec_syn.
module hec_decode #(
  parameter int DW = 57,
  parameter int CW = 63,
  parameter int R  = 6
) (
  input  logic [CW-1:0]             code,
  input  logic [hec_pkg::LEN_W-1:0] code_len,
  output logic [CW-1:0]             fixed,
  output logic [DW-1:0]             data,
  output logic [R-1:0]              syn,
  output logic                      err,
  output logic                      oor
);
  import hec_pkg::*;

  logic [CW-1:0] flip_vec;

  hec_syn #(.CW(CW), .R(R)) u_syn (
    .code (code),
    .syn  (syn)
  );

  // A syndrome past the code length is flagged and nothing is flipped.
  always_comb begin
    err = (syn != '0);
    oor = (LEN_W'(syn) > code_len);
    if (err && !oor) begin
      flip_vec = CW'(1) << (syn - R'(1));
    end else begin
      flip_vec = '0;
    end
    fixed = code ^ flip_vec;
  end

  // Data bits come from the non-power-of-two positions of the corrected word.
  for (genvar p = 1; p <= CW; p++) begin : g_ext
    if (!is_pow2(p)) begin : g_dat
      assign data[data_idx(p)] = fixed[p-1];
    end
  end

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the Hamming encode and correct codec top level.
// It uses hec_pkg and hamming_encode_correct_codec and predicts every result
// bit for bit, with random idle and stall cycles on both stream channels.
`timescale 1ns / 1ps

module testbench;
  import hec_pkg::*;

  localparam int DATA_W  = 57;
  localparam int CODE_W  = 63;
  localparam int IN_W    = 120;
  localparam int OUT_W   = 128;
  localparam int MAX_CYC = 200000;
  localparam int IDLE_PCT = 12;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [DATA_W-1:0] data;
    logic [5:0]        syn;
    logic              err;
    logic              oor;
  } codec_result_t;

  typedef struct {
    op_t               op;
    logic [DATA_W-1:0] data;
    logic [CODE_W-1:0] code;
  } codec_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic              in_tuser = 1'b0;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_wen = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  codec_item_t       pending_q[$];
  codec_result_t     expected_q[$];
  logic [CFG_W-1:0]  length_mirror;
  int                mismatches = 0;
  int                results_seen = 0;
  int                cycle_count = 0;
  int                stall_cycles = 0;
  logic              stall_done = 1'b0;
  logic              calm = 1'b0;

  hamming_encode_correct_codec #(
    .MAX_DATA_BITS(DATA_W)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Codeword length for a data length register value, with the clamping
  // of zero to one and of large values to the maximum.
  function automatic int code_len(input logic [CFG_W-1:0] dl);
    int n;
    int r;
    n = int'(dl);
    if (n < 1) n = 1;
    if (n > DATA_W) n = DATA_W;
    r = 0;
    while ((1 << r) < n + r + 1) r++;
    return n + r;
  endfunction

  // Expected result of one transaction under a given data length.
  function automatic codec_result_t hamming_predict(input op_t op,
                                                    input logic [DATA_W-1:0] din,
                                                    input logic [CODE_W-1:0] cin,
                                                    input logic [CFG_W-1:0] dl);
    codec_result_t res;
    logic [CODE_W-1:0] cw;
    logic [5:0] syn;
    int len;
    int k;
    int p;
    res = '0;
    cw = '0;
    syn = '0;
    len = code_len(dl);
    if (op == OP_ENCODE) begin
      // Scatter data bits over the non-parity positions, then fix parity.
      k = 0;
      for (p = 1; p <= len; p++) begin
        if ((p & (p - 1)) != 0) begin
          cw[p-1] = din[k];
          k++;
        end
      end
      for (p = 1; p <= len; p++) begin
        if (cw[p-1]) syn ^= p[5:0];
      end
      for (k = 0; k < 6; k++) begin
        if ((1 << k) <= len && syn[k]) cw[(1 << k) - 1] = 1'b1;
      end
    end else begin
      // Syndrome over the live positions, then a single flip if in range.
      for (p = 1; p <= len; p++) begin
        cw[p-1] = cin[p-1];
        if (cw[p-1]) syn ^= p[5:0];
      end
      res.syn = syn;
      res.err = (syn != 0);
      if (int'(syn) > len) begin
        res.oor = 1'b1;
      end else if (syn != 0) begin
        cw[syn-1] = ~cw[syn-1];
      end
    end
    k = 0;
    for (p = 1; p <= len; p++) begin
      if ((p & (p - 1)) != 0) begin
        res.data[k] = cw[p-1];
        k++;
      end
    end
    res.code = cw;
    return res;
  endfunction

  function automatic logic [CODE_W-1:0] valid_codeword(input logic [DATA_W-1:0] d,
                                                       input logic [CFG_W-1:0] dl);
    codec_result_t res;
    res = hamming_predict(OP_ENCODE, d, '0, dl);
    return res.code;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic add_item(input op_t op, input logic [DATA_W-1:0] d,
                          input logic [CODE_W-1:0] c);
    codec_item_t it;
    it.op = op;
    it.data = d;
    it.code = c;
    pending_q.insert(pending_q.size(), it);
  endtask

  // Mostly well-formed codewords with zero, one or two flipped bits,
  // plus encodes and raw noise; junk above the code length now and then.
  task automatic queue_random(input int count, input logic [CFG_W-1:0] dl);
    int len;
    int kind;
    int pa;
    int pb;
    logic [CODE_W-1:0] cw;
    logic [CODE_W-1:0] live_mask;
    logic [CODE_W-1:0] junk;
    logic [DATA_W-1:0] d;
    len = code_len(dl);
    live_mask = (63'd1 << len) - 63'd1;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      d = DATA_W'(rand64());
      cw = valid_codeword(d, dl);
      junk = ($urandom_range(0, 3) == 0) ? (CODE_W'(rand64()) & ~live_mask) : '0;
      pa = $urandom_range(1, len);
      pb = $urandom_range(1, len);
      if (kind < 20) begin
        add_item(OP_ENCODE, d, CODE_W'(rand64()));
      end else if (kind < 45) begin
        add_item(OP_DECODE, DATA_W'(rand64()), cw | junk);
      end else if (kind < 75) begin
        cw[pa-1] = ~cw[pa-1];
        add_item(OP_DECODE, DATA_W'(rand64()), cw | junk);
      end else if (kind < 88) begin
        cw[pa-1] = ~cw[pa-1];
        cw[pb-1] = ~cw[pb-1];
        add_item(OP_DECODE, DATA_W'(rand64()), cw | junk);
      end else begin
        add_item(OP_DECODE, DATA_W'(rand64()), CODE_W'(rand64()));
      end
    end
  endtask

  // Wait until every queued transaction has produced its result.
  task automatic drain();
    do @(negedge clk); while (pending_q.size() != 0 || expected_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_length(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // Shadow of the data length register.
  always @(posedge clk) begin
    if (!rst_n) begin
      length_mirror <= 6'd4;
    end else if (cfg_wen) begin
      length_mirror <= cfg_wdata;
    end
  end

  // Input driver: holds an offered transaction until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_q.insert(expected_q.size(),
                          hamming_predict(pending_q[0].op, pending_q[0].data,
                                          pending_q[0].code, length_mirror));
        void'(pending_q.pop_front());
      end
      if (!(in_tvalid && !in_tready)) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_tvalid <= 1'b1;
          in_tuser <= pending_q[0].op;
          in_tdata <= {pending_q[0].code, pending_q[0].data};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side ready, with one long hold-off to back the codec up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_cycles > 0) begin
      out_tready <= 1'b0;
      stall_cycles <= stall_cycles - 1;
    end else if (!stall_done && results_seen >= 400) begin
      stall_done <= 1'b1;
      stall_cycles <= 80;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // Result monitor: compare each transaction with the oldest expectation.
  always @(posedge clk) begin
    codec_result_t got;
    codec_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.code = out_tdata[62:0];
      got.data = out_tdata[119:63];
      got.syn  = out_tdata[125:120];
      got.err  = out_tdata[126];
      got.oor  = out_tdata[127];
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %h", out_tdata));
      end else begin
        want = expected_q.pop_front();
        if (got.code !== want.code)
          report_mismatch($sformatf("code_out %h, expected %h", got.code, want.code));
        if (got.data !== want.data)
          report_mismatch($sformatf("data_out %h, expected %h", got.data, want.data));
        if (got.syn !== want.syn)
          report_mismatch($sformatf("syndrome %0d, expected %0d", got.syn, want.syn));
        if (got.err !== want.err)
          report_mismatch($sformatf("error_found %b, expected %b", got.err, want.err));
        if (got.oor !== want.oor)
          report_mismatch($sformatf("syndrome_out_of_range %b, expected %b",
                                    got.oor, want.oor));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYC) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus sequence, one data length setting per phase.
  initial begin
    logic [CFG_W-1:0] length_plan[10];
    logic [CODE_W-1:0] cw;
    logic [CFG_W-1:0] v;
    length_plan = '{6'd1, 6'd57, 6'd0, 6'd63, 6'd11, 6'd26, 6'd2, 6'd33, 6'd58, 6'd4};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset length of four: field extremes, parity and last-position errors.
    add_item(OP_ENCODE, '0, '0);
    add_item(OP_ENCODE, '1, '1);
    add_item(OP_DECODE, '0, '0);
    add_item(OP_DECODE, '1, '1);
    cw = valid_codeword(57'hB, 6'd4);
    add_item(OP_DECODE, '0, cw ^ 63'h1);
    add_item(OP_DECODE, '0, cw ^ 63'h40);
    add_item(OP_DECODE, '1, valid_codeword('0, 6'd4) ^ 63'h4);
    queue_random(95, 6'd4);
    drain();

    // Length five gives a code length of nine, so syndromes can overrun it.
    write_length(6'd5);
    cw = valid_codeword('1, 6'd5);
    add_item(OP_ENCODE, '1, '1);
    add_item(OP_DECODE, '0, cw);
    add_item(OP_DECODE, '0, cw ^ 63'h100);
    add_item(OP_DECODE, '0, cw ^ 63'h0C0);
    add_item(OP_DECODE, '0, cw ^ 63'h088);
    add_item(OP_DECODE, '0, '1);
    queue_random(95, 6'd5);
    drain();

    foreach (length_plan[i]) begin
      write_length(length_plan[i]);
      calm = (length_plan[i] == 6'd57);
      queue_random(95, length_plan[i]);
      drain();
    end
    calm = 1'b0;

    repeat (2) begin
      v = CFG_W'($urandom_range(0, 63));
      write_length(v);
      queue_random(95, v);
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- hamming_encode_correct_codec.f -----
sv/hec_pkg.sv
sv/hec_cfg.sv
sv/hec_syn.sv
sv/hec_encode.sv
sv/hec_decode.sv
sv/hamming_encode_correct_codec.sv
dv/testbench.sv
